FILE: sv/ppab_pkg.sv
// Shared types and constants for the pixel pack and alpha blend block.
// Holds register codes, format codes and the byte placement table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppab_pkg;

	localparam int CH_W    = 16;          // Q1.15 channel width
	localparam int PROD_W  = 31;          // channel times alpha, at most 2^30
	localparam int OLDW_W  = 23;          // (1 - alpha) times old byte, below 2^23
	localparam int ACC_W   = 38;          // full blend sum, at most 255 * 2^30
	localparam int FRAC_SH = 30;          // Q1.15 times Q1.15 gives Q.30

	localparam logic [CH_W-1:0] ONE_Q15 = 16'h8000;

	// APB register addresses
	localparam logic [2:0] ADDR_PIXEL_FORMAT = 3'd0;
	localparam logic [2:0] ADDR_SAMPLE_COUNT = 3'd4;

	// pixel_format codes
	localparam logic [3:0] FMT_RGB16      = 4'd0;
	localparam logic [3:0] FMT_ABGR32     = 4'd11;

	// sample_count codes
	localparam logic [2:0] SC_NONE        = 3'd0;
	localparam logic [2:0] SC_GREY        = 3'd1;
	localparam logic [2:0] SC_GREY_ALPHA  = 3'd2;
	localparam logic [2:0] SC_RGB         = 3'd3;
	localparam logic [2:0] SC_RGBA        = 3'd4;

	// lanes
	localparam int LANE_R = 0;
	localparam int LANE_G = 1;
	localparam int LANE_B = 2;
	localparam int LANE_A = 3;

	typedef logic [1:0] byte_idx_t;
	typedef logic [3:0][CH_W-1:0] chan_vec_t;
	typedef logic [3:0][7:0] byte_vec_t;

	// byte slot of lanes r, g, b, a for the 32-bit formats rgba, argb, bgra, abgr
	localparam byte_idx_t BYTE_POS [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd2, 2'd3, 2'd0},
		'{2'd2, 2'd1, 2'd0, 2'd3},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};

endpackage : ppab_pkg

`default_nettype wire

FILE: sv/pixel_pack_alpha_blend.sv
// Top level of the pixel pack and alpha blend block: stream ports, APB registers
// and a four-stage datapath. Depends on ppab_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Pixel pack and alpha-over blend. Each input transfer carries four Q1.15
// channels (values above 32768 are clamped to one) and the framebuffer word
// now held at the pixel; each output transfer carries the new word and a
// write enable in tuser. Formats 0..7 give 16- or 15-bit RGB/BGR words,
// native or byte-swapped, premultiplied by alpha; formats 8..11 give 32-bit
// rgba/argb/bgra/abgr words blended over the old pixel. A sample count of
// zero or an unused format code returns a zero word with write enable low.
// The datapath is four register stages (select and clamp, 16x16 multiply,
// scale by 255, blend add and pack). The input transfer edge loads stage 1,
// and the pixel then passes through stages 2 and 3 into stage 4; one pixel
// enters every clock while s_tready is high. The fourth stage is the output
// register, and a stall on the master side fills the empty stages behind it
// before tready drops.
// Write pixel_format and sample_count only while no pixel is in flight.
module pixel_pack_alpha_blend (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,  // red[15:0], green[31:16], blue[47:32],
	                                   // alpha[63:48], old_pixel[95:64]
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // new_pixel[31:0]
	output logic [0:0]       m_tuser,  // write_enable[0]
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import ppab_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [3:0] fmt_q;
	logic [2:0] sc_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB16;
			sc_q  <= SC_RGBA;
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_PIXEL_FORMAT: fmt_q <= pwdata[3:0];
				ADDR_SAMPLE_COUNT: sc_q  <= pwdata[2:0];
				default: ;   // drop writes outside the register map
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_PIXEL_FORMAT: prdata = {28'd0, fmt_q};
			ADDR_SAMPLE_COUNT: prdata = {29'd0, sc_q};
			default:           prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its successor loads
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 | m_tready;
	assign rdy3     = !v_s3 | rdy4;
	assign rdy2     = !v_s2 | rdy3;
	assign rdy1     = !v_s1 | rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: clamp, pick lanes by sample count, fetch old bytes
	// Every mode maps onto blend(c, a, old) per lane: without alpha the
	// lane uses a = one and old = 0, which reduces to floor(c*255).
	// ------------------------------------------------------------------
	logic [CH_W-1:0] fr, fg, fb, fa;
	logic [31:0]     old_word;
	logic [2:0]      n_eff;
	chan_vec_t       c_d;
	logic [CH_W-1:0] a_d;
	logic            has_alpha;
	byte_vec_t       old_d;
	byte_vec_t       old_bytes;
	logic            wide;
	logic            we_d;

	function automatic logic [CH_W-1:0] clamp_q(input logic [CH_W-1:0] v);
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

	assign fr        = clamp_q(s_tdata[15:0]);
	assign fg        = clamp_q(s_tdata[31:16]);
	assign fb        = clamp_q(s_tdata[47:32]);
	assign fa        = clamp_q(s_tdata[63:48]);
	assign old_word  = s_tdata[95:64];
	assign old_bytes = old_word;
	assign n_eff     = (sc_q > SC_RGBA) ? SC_RGBA : sc_q;
	assign wide      = fmt_q[3];
	assign we_d      = (n_eff != SC_NONE) && (fmt_q <= FMT_ABGR32);

	always_comb begin
		c_d       = '0;
		a_d       = ONE_Q15;
		has_alpha = 1'b0;
		case (n_eff)
			SC_GREY: begin
				c_d = {fr, fr, fr, fr};
			end
			SC_GREY_ALPHA: begin
				c_d       = {ONE_Q15, fr, fr, fr};
				a_d       = fg;
				has_alpha = 1'b1;
			end
			SC_RGB: begin
				c_d = {{CH_W{1'b0}}, fb, fg, fr};
			end
			default: begin
				c_d       = {ONE_Q15, fb, fg, fr};
				a_d       = fa;
				has_alpha = 1'b1;
			end
		endcase
	end

	// old bytes take part only when blending into a 32-bit word
	always_comb begin
		old_d = '0;
		if (has_alpha && wide) begin
			for (int l = 0; l < 4; l++) begin
				old_d[l] = old_bytes[BYTE_POS[fmt_q[1:0]][l]];
			end
		end
	end

	chan_vec_t       c_s1;
	logic [CH_W-1:0] a_s1;
	byte_vec_t       old_s1;
	logic [3:0]      fmt_s1;
	logic            we_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			c_s1   <= c_d;
			a_s1   <= a_d;
			old_s1 <= old_d;
			fmt_s1 <= fmt_q;
			we_s1  <= we_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: c*a and (1-a)*old for each lane
	// ------------------------------------------------------------------
	logic [CH_W-1:0]             inv_a;
	logic [3:0][PROD_W-1:0]      prod_s2;
	logic [3:0][OLDW_W-1:0]      oldw_s2;
	logic [3:0]                  fmt_s2;
	logic                        we_s2;
	logic [3:0][2*CH_W-1:0]      prod_d;
	logic [3:0][CH_W+7:0]        oldw_d;

	assign inv_a = ONE_Q15 - a_s1;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			prod_d[l] = c_s1[l] * a_s1;
			oldw_d[l] = inv_a * old_s1[l];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int l = 0; l < 4; l++) begin
				prod_s2[l] <= prod_d[l][PROD_W-1:0];
				oldw_s2[l] <= oldw_d[l][OLDW_W-1:0];
			end
			fmt_s2 <= fmt_s1;
			we_s2  <= we_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: scale c*a by 255 as a shift and subtract
	// ------------------------------------------------------------------
	logic [3:0][PROD_W+8:0] scl_d;
	logic [3:0][ACC_W-1:0]  scl_s3;
	logic [3:0][OLDW_W-1:0] oldw_s3;
	logic [3:0]             fmt_s3;
	logic                   we_s3;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			scl_d[l] = {prod_s2[l], 8'd0} - {8'd0, prod_s2[l]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int l = 0; l < 4; l++) begin
				scl_s3[l] <= scl_d[l][ACC_W-1:0];
			end
			oldw_s3 <= oldw_s2;
			fmt_s3  <= fmt_s2;
			we_s3   <= we_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: add the old-pixel term, take the floor and pack the word
	// ------------------------------------------------------------------
	logic [3:0][ACC_W-1:0] sum_d;
	byte_vec_t             ch8;
	logic [15:0]           narrow_w;
	logic [7:0]            lo8, hi8;
	byte_vec_t             wide_w;
	logic [31:0]           pix_d;
	logic [31:0]           new_s4;
	logic                  we_s4;
	logic [3:0]            fmt_s4;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			sum_d[l] = scl_s3[l] + {oldw_s3[l], 15'd0};
			ch8[l]   = sum_d[l][FRAC_SH+7:FRAC_SH];
		end
	end

	// bgr formats keep red in the high field
	assign lo8 = fmt_s3[1] ? ch8[LANE_B] : ch8[LANE_R];
	assign hi8 = fmt_s3[1] ? ch8[LANE_R] : ch8[LANE_B];

	always_comb begin
		if (!fmt_s3[2]) begin
			narrow_w = {hi8[7:3], ch8[LANE_G][7:2], lo8[7:3]};
		end else begin
			narrow_w = {1'b0, hi8[7:3], ch8[LANE_G][7:3], lo8[7:3]};
		end
		if (fmt_s3[0]) begin
			narrow_w = {narrow_w[7:0], narrow_w[15:8]};
		end
	end

	always_comb begin
		wide_w = '0;
		for (int l = 0; l < 4; l++) begin
			wide_w[BYTE_POS[fmt_s3[1:0]][l]] = ch8[l];
		end
	end

	always_comb begin
		if (!we_s3) begin
			pix_d = 32'd0;
		end else if (fmt_s3[3]) begin
			pix_d = wide_w;
		end else begin
			pix_d = {16'd0, narrow_w};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			new_s4 <= pix_d;
			we_s4  <= we_s3;
			fmt_s4 <= fmt_s3;
		end
	end

	assign m_tdata    = new_s4;
	assign m_tuser[0] = we_s4;

`ifndef SYNTHESIS
	// a pixel that is not written carries a zero word
	a_we_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("unwritten pixel carries a non-zero word");

	// narrow formats leave the upper half clear
	a_narrow_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !fmt_s4[3]) |-> (m_tdata[31:16] == 16'd0))
		else $error("narrow format word has upper bits set");

	// an input transfer always lands in the first stage
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted pixel lost at stage 1");

	// a pixel leaving stage 3 always lands in the output register
	a_enter_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy4) |=> v_s4)
		else $error("pixel lost between stage 3 and output");
`endif

endmodule : pixel_pack_alpha_blend

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for pixel_pack_alpha_blend: stream driver, APB register writes and
// a scoreboard fed by a clamp/premultiply/blend/pack predictor. Depends on ppab_pkg.
`timescale 1ns / 1ps

module tb_top;

	import ppab_pkg::*;

	// pixel_format codes, in register order
	localparam logic [3:0] PF_RGB16     = 4'd0;
	localparam logic [3:0] PF_RGB16_SW  = 4'd1;
	localparam logic [3:0] PF_BGR16     = 4'd2;
	localparam logic [3:0] PF_BGR16_SW  = 4'd3;
	localparam logic [3:0] PF_RGB15     = 4'd4;
	localparam logic [3:0] PF_RGB15_SW  = 4'd5;
	localparam logic [3:0] PF_BGR15     = 4'd6;
	localparam logic [3:0] PF_BGR15_SW  = 4'd7;
	localparam logic [3:0] PF_RGBA32    = 4'd8;
	localparam logic [3:0] PF_ARGB32    = 4'd9;
	localparam logic [3:0] PF_BGRA32    = 4'd10;
	localparam logic [3:0] PF_ABGR32    = 4'd11;
	localparam logic [3:0] PF_UNUSED_HI = 4'd15;

	localparam int HOLD_CYCLES   = 60;    // long back-pressure stretch on the output
	localparam int STALL_LIMIT   = 1000;  // cycles without any transfer before giving up
	localparam int TAIL_CYCLES   = 12;    // pipeline depth plus margin

	typedef struct packed {
		logic [31:0] new_pixel;
		logic        write_enable;
	} pixel_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;   // red[15:0], green[31:16], blue[47:32], alpha[63:48],
	                             // old_pixel[95:64]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // new_pixel[31:0]
	logic [0:0]  m_tuser;        // write_enable[0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// bench copy of the two registers, as reset leaves them
	logic [3:0]  cur_format = PF_RGB16;
	logic [2:0]  cur_samples = SC_RGBA;

	logic [95:0]  pending_pixels[$];
	pixel_word_t  expected_pixels[$];

	logic in_done = 1'b0;   // input transfer seen at the last rising edge
	logic idle_on = 1'b1;   // allow random idle bursts on both sides
	logic hold_req = 1'b0;  // ask the receiver for one long hold-off
	int   src_gap = 0;
	int   sink_gap = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	int   errors = 0;

	pixel_pack_alpha_blend u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor: clamp to one, scale to 8 bits, premultiply or blend, pack
	// ---------------------------------------------------------------
	function automatic logic [15:0] clamp_q15(logic [15:0] v);
		return (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

	function automatic logic [7:0] scale_byte(logic [15:0] v);
		return 8'((32'(v) * 32'd255) >> 15);
	endfunction

	function automatic logic [7:0] premul_byte(logic [15:0] c, logic [15:0] a);
		return 8'((64'(c) * 64'(a) * 64'd255) >> 30);
	endfunction

	// c*a*255 + (1-a)*prev, all in Q.30, floored
	function automatic logic [7:0] blend_byte(logic [15:0] c, logic [15:0] a, logic [7:0] prev);
		logic [63:0] acc;
		acc = 64'(c) * 64'(a) * 64'd255 + (64'(ONE_Q15) - 64'(a)) * 64'(prev) * 64'd32768;
		return 8'(acc >> 30);
	endfunction

	function automatic pixel_word_t predict_pixel(logic [3:0] fmt, logic [2:0] sc,
			logic [95:0] d);
		logic [15:0] cr, cg, cb, ca;
		logic [31:0] prev;
		logic [7:0]  r8, g8, b8, a8, lo, hi;
		logic [15:0] w;
		logic        has_alpha;
		int          sh_r, sh_g, sh_b, sh_a;
		pixel_word_t res;
		res = '0;
		cr = clamp_q15(d[15:0]);
		cg = clamp_q15(d[31:16]);
		cb = clamp_q15(d[47:32]);
		ca = clamp_q15(d[63:48]);
		prev = d[95:64];
		if (sc == SC_NONE || fmt > PF_ABGR32)
			return res;
		has_alpha = 1'b0;
		r8 = '0; g8 = '0; b8 = '0; a8 = '0;
		case (sc)
			SC_GREY: begin
				r8 = scale_byte(cr);
				g8 = r8; b8 = r8; a8 = r8;
			end
			SC_RGB: begin
				r8 = scale_byte(cr);
				g8 = scale_byte(cg);
				b8 = scale_byte(cb);
			end
			SC_GREY_ALPHA: begin
				// green carries alpha; grey goes to every colour lane
				has_alpha = 1'b1;
				ca = cg; cg = cr; cb = cr;
			end
			default: has_alpha = 1'b1;   // rgba, and any count above four
		endcase
		if (fmt < PF_RGBA32) begin
			if (has_alpha) begin
				r8 = premul_byte(cr, ca);
				g8 = premul_byte(cg, ca);
				b8 = premul_byte(cb, ca);
			end
			lo = fmt[1] ? b8 : r8;
			hi = fmt[1] ? r8 : b8;
			if (fmt < PF_RGB15)
				w = {hi[7:3], g8[7:2], lo[7:3]};
			else
				w = {1'b0, hi[7:3], g8[7:3], lo[7:3]};
			if (fmt[0])
				w = {w[7:0], w[15:8]};
			res.new_pixel = {16'h0000, w};
		end else begin
			case (fmt)
				PF_RGBA32: begin sh_r = 0;  sh_g = 8;  sh_b = 16; sh_a = 24; end
				PF_ARGB32: begin sh_r = 8;  sh_g = 16; sh_b = 24; sh_a = 0;  end
				PF_BGRA32: begin sh_r = 16; sh_g = 8;  sh_b = 0;  sh_a = 24; end
				default:   begin sh_r = 24; sh_g = 16; sh_b = 8;  sh_a = 0;  end
			endcase
			if (has_alpha) begin
				r8 = blend_byte(cr, ca, 8'(prev >> sh_r));
				g8 = blend_byte(cg, ca, 8'(prev >> sh_g));
				b8 = blend_byte(cb, ca, 8'(prev >> sh_b));
				a8 = blend_byte(ONE_Q15, ca, 8'(prev >> sh_a));
			end
			res.new_pixel = (32'(r8) << sh_r) | (32'(g8) << sh_g) |
			                (32'(b8) << sh_b) | (32'(a8) << sh_a);
		end
		res.write_enable = 1'b1;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [95:0] make_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [15:0] a, logic [31:0] prev);
		return {prev, a, b, g, r};
	endfunction

	// weight the ends of the range and values above one that must clamp
	function automatic logic [15:0] pick_channel();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return ONE_Q15;
			2: return 16'($urandom);
			3: return ONE_Q15 - 16'd1;
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [95:0] random_pixel();
		return make_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(),
		                  32'($urandom));
	endfunction

	// APB write: setup cycle, then access cycle until pready
	task automatic write_register(logic [2:0] addr, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_PIXEL_FORMAT)
			cur_format = value[3:0];
		else if (addr == ADDR_SAMPLE_COUNT)
			cur_samples = value[2:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// upper data bits are don't-care, so fill them at random
	task automatic apply_setting(logic [3:0] fmt, logic [2:0] sc);
		write_register(ADDR_PIXEL_FORMAT, {28'($urandom), fmt});
		write_register(ADDR_SAMPLE_COUNT, {29'($urandom), sc});
	endtask

	// hold the thread until every queued pixel has gone in and come back
	task automatic drain();
		while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Input driver: hold tdata until transfer, then present the next pixel
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!(s_tvalid && !in_done)) begin
			if (src_gap > 0) begin
				src_gap = src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (arst_n && pending_pixels.size() != 0) begin
				s_tdata  <= pending_pixels.pop_front();
				s_tvalid <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 5);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output ready: one long hold-off on request, else random short bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap = sink_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0)
				sink_gap = $urandom_range(1, 5);
		end
	end

	// ---------------------------------------------------------------
	// Monitor and scoreboard: predict on input transfer, check on output transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		pixel_word_t want;
		in_done <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			expected_pixels.push_back(predict_pixel(cur_format, cur_samples, s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected output transfer: new_pixel %h write_enable %b",
				       m_tdata, m_tuser[0]);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata !== want.new_pixel) begin
					$error("new_pixel: expected %h, actual %h", want.new_pixel, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.write_enable) begin
					$error("write_enable: expected %b, actual %b",
					       want.write_enable, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// Watchdog: give up after a long run of cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		logic [95:0] corner_pixels[8];
		int phase;
		logic [3:0] fmt;
		logic [2:0] sc;

		corner_pixels[0] = make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		corner_pixels[1] = make_pixel(ONE_Q15, ONE_Q15, ONE_Q15, ONE_Q15, 32'hFFFF_FFFF);
		corner_pixels[2] = make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
		// transparent: in a 32-bit format the old pixel must come through
		corner_pixels[3] = make_pixel(ONE_Q15, 16'h0000, 16'h4000, 16'h0000, 32'hFFFF_FFFF);
		corner_pixels[4] = make_pixel(16'h0000, ONE_Q15, 16'h0000, ONE_Q15, 32'h1234_5678);
		corner_pixels[5] = make_pixel(16'h7FFF, 16'h0001, 16'h8001, 16'h4000, 32'hA5A5_A5A5);
		corner_pixels[6] = make_pixel(16'h8000, 16'h4000, 16'h2000, 16'h7FFF, 32'h5A5A_5A5A);
		corner_pixels[7] = make_pixel(16'h7FFF, 16'hFFFF, 16'h8001, 16'hFFFF, 32'h80FF_017F);

		// reset once, released on a falling clock edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners: reset setting, then a wide blend and a narrow swapped grey
		foreach (corner_pixels[i])
			pending_pixels.push_back(corner_pixels[i]);
		drain();
		apply_setting(PF_ABGR32, SC_RGBA);
		foreach (corner_pixels[i])
			pending_pixels.push_back(corner_pixels[i]);
		drain();
		apply_setting(PF_BGR15_SW, SC_GREY_ALPHA);
		foreach (corner_pixels[i])
			pending_pixels.push_back(corner_pixels[i]);
		drain();

		// sweep every valid format against every sample count
		phase = 0;
		for (int f = 0; f <= 11; f++) begin
			for (int s = 0; s <= 4; s++) begin
				idle_on = (phase % 3) != 0;
				apply_setting(4'(f), 3'(s));
				// back-pressure: the block must fill and drop s_tready
				if (phase == 7 || phase == 40)
					hold_req = 1'b1;
				repeat (14)
					pending_pixels.push_back(random_pixel());
				drain();
				phase++;
			end
		end

		// out-of-range codes: unused formats and counts above four, then random codes
		idle_on = 1'b1;
		for (int p = 0; p < 12; p++) begin
			if (p == 0) begin
				fmt = PF_UNUSED_HI;
				sc  = 3'd7;
			end else if (p == 1) begin
				fmt = PF_RGBA32;
				sc  = 3'd7;
			end else begin
				fmt = 4'($urandom_range(0, 15));
				sc  = 3'($urandom_range(0, 7));
			end
			apply_setting(fmt, sc);
			repeat (15)
				pending_pixels.push_back(random_pixel());
			drain();
		end

		// closing stretch at full rate, no idling on either side
		idle_on = 1'b0;
		apply_setting(PF_ARGB32, SC_GREY_ALPHA);
		repeat (30)
			pending_pixels.push_back(random_pixel());
		drain();

		// let any stray output show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
